// ----- src/rtcm_pkg.sv -----
package rtcm_pkg;

	// Depth of the request queue between the front and the back.
	localparam int QueueDepth = 2;
	localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	// Fixed bytes and field codes of the serial protocol.
	localparam logic [7:0] WP_CMD_BYTE      = 8'h8E;
	localparam logic [7:0] WP_DATA_BYTE     = 8'h00;
	localparam logic [7:0] HALF_BIT_RESET   = 8'd16;
	localparam logic [3:0] CMD_CLOCK_PREFIX = 4'b1000;
	localparam logic [1:0] CMD_RAM_PREFIX   = 2'b11;
	localparam logic [2:0] FIELD_HOUR       = 3'd2;
	localparam logic [2:0] FIELD_WEEKDAY    = 3'd5;
	localparam logic [2:0] LAST_BIT         = 3'd7;
	localparam logic [7:0] HOUR12_MASK      = 8'b0001_1111;
	localparam logic [7:0] HOUR24_MASK      = 8'b0011_1111;
	localparam logic [7:0] BCD_MAX          = 8'd99;
	localparam int         PM_BIT           = 5;
	localparam int         TWELVE_BIT       = 7;

	// Transaction sequencer steps.
	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_WP_CMD  = 8'b0000_0010,
		ST_WP_DATA = 8'b0000_0100,
		ST_GAP     = 8'b0000_1000,
		ST_CMD     = 8'b0001_0000,
		ST_WDATA   = 8'b0010_0000,
		ST_RDATA   = 8'b0100_0000,
		ST_END     = 8'b1000_0000
	} step_t;

	// One classified tick as it travels from the front to the back.
	typedef struct packed {
		logic       start;
		logic       is_write;
		logic       is_raw;
		logic       is_hour;
		logic [7:0] cmd;
		logic [7:0] wdata;
		logic       din;
	} item_t;

	// Pin levels and status produced for one tick.
	typedef struct packed {
		logic       chip_enable;
		logic       serial_clock;
		logic       data_pin_out;
		logic       data_drive;
		logic       busy;
		logic       done;
		logic [7:0] read_value;
		logic       read_pm;
		logic       read_twelve_hour;
	} result_t;

	// Binary to BCD with saturation at 99; tens found by a reciprocal multiply.
	function automatic logic [7:0] to_bcd(input logic [7:0] v);
		logic [6:0]  sat;
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  tens_x10;
		logic [6:0]  units;
		sat      = (v > BCD_MAX) ? BCD_MAX[6:0] : v[6:0];
		prod     = 15'(sat) * 15'd205;
		tens     = prod[14:11];
		tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
		units    = sat - tens_x10;
		return {tens, units[3:0]};
	endfunction

	// BCD to binary, digits unchecked.
	function automatic logic [7:0] from_bcd(input logic [7:0] b);
		logic [7:0] t;
		t = {4'b0000, b[7:4]};
		return (t << 3) + (t << 1) + {4'b0000, b[3:0]};
	endfunction

endpackage

// ----- src/rtcm_front.sv -----
module rtcm_front import rtcm_pkg::*; (
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       start_req,
	input  logic [1:0] operation,
	input  logic [2:0] field_index,
	input  logic [4:0] ram_offset,
	input  logic [7:0] write_value,
	input  logic       write_pm,
	input  logic       write_twelve_hour,
	input  logic       data_pin_in,
	input  logic       q_full,
	output logic       q_push,
	output item_t      q_item
);

	logic       is_ram;
	logic       is_hour;
	logic       is_weekday;
	logic [7:0] bcd_value;

	// Accept a tick whenever the queue has room.
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Classify the request and build its command and data bytes.
	assign is_ram     = operation[1];
	assign is_hour    = !is_ram && (field_index == FIELD_HOUR);
	assign is_weekday = !is_ram && (field_index == FIELD_WEEKDAY);
	assign bcd_value  = to_bcd(write_value);

	always_comb begin
		q_item          = '0;
		q_item.start    = start_req;
		q_item.is_write = operation[0];
		q_item.is_raw   = is_ram || is_weekday;
		q_item.is_hour  = is_hour;
		q_item.din      = data_pin_in;
		if (is_ram) begin
			q_item.cmd = {CMD_RAM_PREFIX, ram_offset, !operation[0]};
		end else begin
			q_item.cmd = {CMD_CLOCK_PREFIX, field_index, !operation[0]};
		end
		if (is_ram || is_weekday) begin
			q_item.wdata = write_value;
		end else if (is_hour) begin
			q_item.wdata = bcd_value;
			q_item.wdata[PM_BIT]     = bcd_value[PM_BIT] | write_pm;
			q_item.wdata[TWELVE_BIT] = bcd_value[TWELVE_BIT] | write_twelve_hour;
		end else begin
			q_item.wdata = bcd_value;
		end
	end

endmodule

// ----- src/rtcm_queue.sv -----
module rtcm_queue import rtcm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t pop_item,
	output logic  full,
	output logic  empty
);

	item_t                 mem_q [QueueDepth];
	logic [QueuePtrW-1:0]  wr_ptr_q;
	logic [QueuePtrW-1:0]  rd_ptr_q;
	logic [QueueCntW-1:0]  count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full     = (count_q == QueueCntW'(QueueDepth));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0
					: wr_ptr_q + QueuePtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0
					: rd_ptr_q + QueuePtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QueueCntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QueueCntW'(1);
			end
		end
	end

endmodule

// ----- src/rtcm_back.sv -----
module rtcm_back import rtcm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  logic [7:0] cfg_write_data,
	input  logic       q_empty,
	input  item_t      q_item,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    result
);

	logic [7:0] half_bit_q;
	step_t      step_q;
	logic       high_q;
	logic [2:0] bit_q;
	logic [7:0] delay_q;
	logic [7:0] shift_q;
	item_t      held_q;
	logic [7:0] last_value_q;
	logic       last_pm_q;
	logic       last_twelve_q;
	result_t    out_q;
	logic       out_valid_q;

	step_t      cur_step;
	logic       cur_high;
	logic [2:0] cur_bit;
	logic [7:0] cur_delay;
	logic [7:0] cur_shift;
	item_t      cur_held;
	step_t      nxt_step;
	logic       nxt_high;
	logic [2:0] nxt_bit;
	logic [7:0] nxt_delay;
	logic [7:0] nxt_shift;
	logic [7:0] nxt_value;
	logic       nxt_pm;
	logic       nxt_twelve;
	logic [7:0] limit;
	logic [7:0] delay_inc;
	logic [7:0] hour_bits;
	result_t    res;

	// Take the next tick once the result register can move on.
	assign q_pop     = !q_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result    = out_q;

	assign limit     = (half_bit_q == '0) ? 8'd1 : half_bit_q;
	assign hour_bits = cur_shift[TWELVE_BIT] ? (cur_shift & HOUR12_MASK)
		: (cur_shift & HOUR24_MASK);

	// One tick of the transaction sequencer.
	always_comb begin
		cur_step  = step_q;
		cur_high  = high_q;
		cur_bit   = bit_q;
		cur_delay = delay_q;
		cur_shift = shift_q;
		cur_held  = held_q;

		// A new request is taken only while idle and starts on this tick.
		if (step_q == ST_IDLE && q_item.start) begin
			cur_held  = q_item;
			cur_step  = q_item.is_write ? ST_WP_CMD : ST_CMD;
			cur_high  = 1'b0;
			cur_bit   = '0;
			cur_delay = '0;
			cur_shift = q_item.is_write ? WP_CMD_BYTE : q_item.cmd;
		end

		nxt_step   = cur_step;
		nxt_high   = cur_high;
		nxt_bit    = cur_bit;
		nxt_delay  = cur_delay;
		nxt_shift  = cur_shift;
		nxt_value  = last_value_q;
		nxt_pm     = last_pm_q;
		nxt_twelve = last_twelve_q;
		delay_inc  = cur_delay + 8'd1;
		res        = '0;

		if (cur_step != ST_IDLE) begin
			res.busy = 1'b1;

			// Pin levels for this tick.
			if (cur_step != ST_GAP && cur_step != ST_END) begin
				res.chip_enable  = 1'b1;
				res.serial_clock = cur_high;
				if (cur_step == ST_RDATA) begin
					if (!cur_high && cur_delay == '0) begin
						nxt_shift = {q_item.din, cur_shift[7:1]};
					end
				end else begin
					res.data_drive   = 1'b1;
					res.data_pin_out = cur_shift[0];
				end
			end

			// Phase timing and step advance.
			if (delay_inc < limit) begin
				nxt_delay = delay_inc;
			end else if (cur_step == ST_GAP) begin
				nxt_step  = ST_CMD;
				nxt_high  = 1'b0;
				nxt_bit   = '0;
				nxt_delay = '0;
				nxt_shift = cur_held.cmd;
			end else if (cur_step == ST_END) begin
				res.done  = 1'b1;
				nxt_step  = ST_IDLE;
				nxt_high  = 1'b0;
				nxt_bit   = '0;
				nxt_delay = '0;
			end else if (!cur_high) begin
				nxt_delay = '0;
				nxt_high  = 1'b1;
			end else begin
				nxt_delay = '0;
				nxt_high  = 1'b0;
				if (cur_step != ST_RDATA) begin
					nxt_shift = {1'b0, cur_shift[7:1]};
				end
				if (cur_bit != LAST_BIT) begin
					nxt_bit = cur_bit + 3'd1;
				end else begin
					nxt_bit = '0;
					case (cur_step)
						ST_WP_CMD: begin
							nxt_step  = ST_WP_DATA;
							nxt_shift = WP_DATA_BYTE;
						end
						ST_WP_DATA: begin
							nxt_step = ST_GAP;
						end
						ST_CMD: begin
							nxt_step  = cur_held.is_write ? ST_WDATA : ST_RDATA;
							nxt_shift = cur_held.is_write ? cur_held.wdata : 8'h00;
						end
						default: begin
							// Data byte finished: store a read, then close.
							if (cur_step == ST_RDATA) begin
								if (cur_held.is_raw) begin
									nxt_value = cur_shift;
								end else if (cur_held.is_hour) begin
									nxt_value  = from_bcd(hour_bits);
									nxt_pm     = cur_shift[PM_BIT];
									nxt_twelve = cur_shift[TWELVE_BIT];
								end else begin
									nxt_value = from_bcd(cur_shift);
								end
							end
							nxt_step = ST_END;
						end
					endcase
				end
			end
		end

		res.read_value       = nxt_value;
		res.read_pm          = nxt_pm;
		res.read_twelve_hour = nxt_twelve;
	end

	// Held request fields.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			held_q <= cur_held;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= res;
		end
	end

	// Configuration, sequencer state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_q    <= HALF_BIT_RESET;
			step_q        <= ST_IDLE;
			high_q        <= 1'b0;
			bit_q         <= '0;
			delay_q       <= '0;
			shift_q       <= '0;
			last_value_q  <= '0;
			last_pm_q     <= 1'b0;
			last_twelve_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				half_bit_q <= cfg_write_data;
			end
			if (q_pop) begin
				step_q        <= nxt_step;
				high_q        <= nxt_high;
				bit_q         <= nxt_bit;
				delay_q       <= nxt_delay;
				shift_q       <= nxt_shift;
				last_value_q  <= nxt_value;
				last_pm_q     <= nxt_pm;
				last_twelve_q <= nxt_twelve;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/three_wire_rtc_master.sv -----
// Three-wire serial clock chip master; each request is one tick of pin activity.
// A tick's result passes through the queue and then the result register before it reaches the outputs.
// Throughput: one tick per cycle from the back end's sequencer unless out_ready stalls it.
// A two-entry queue lets intake continue while a result waits on the output side.
// Reset (arst_n low, asynchronous) empties the queue, idles the sequencer, clears the
// last read value and loads a half bit time of 16 ticks.
module three_wire_rtc_master import rtcm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  logic [7:0] cfg_write_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       start_req,
	input  logic [1:0] operation,
	input  logic [2:0] field_index,
	input  logic [4:0] ram_offset,
	input  logic [7:0] write_value,
	input  logic       write_pm,
	input  logic       write_twelve_hour,
	input  logic       data_pin_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       chip_enable,
	output logic       serial_clock,
	output logic       data_pin_out,
	output logic       data_drive,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_value,
	output logic       read_pm,
	output logic       read_twelve_hour
);

	logic    q_push;
	logic    q_pop;
	logic    q_full;
	logic    q_empty;
	item_t   push_item;
	item_t   pop_item;
	result_t result;

	// Intake and classification.
	rtcm_front u_front (
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.start_req         (start_req),
		.operation         (operation),
		.field_index       (field_index),
		.ram_offset        (ram_offset),
		.write_value       (write_value),
		.write_pm          (write_pm),
		.write_twelve_hour (write_twelve_hour),
		.data_pin_in       (data_pin_in),
		.q_full            (q_full),
		.q_push            (q_push),
		.q_item            (push_item)
	);

	// Request queue between front and back.
	rtcm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Transaction sequencer and result register.
	rtcm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.q_empty        (q_empty),
		.q_item         (pop_item),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result         (result)
	);

	assign chip_enable      = result.chip_enable;
	assign serial_clock     = result.serial_clock;
	assign data_pin_out     = result.data_pin_out;
	assign data_drive       = result.data_drive;
	assign busy_res         = result.busy;
	assign done_res         = result.done;
	assign read_value       = result.read_value;
	assign read_pm          = result.read_pm;
	assign read_twelve_hour = result.read_twelve_hour;

	// A completing tick always belongs to a request in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> busy_res)
		else $error("done without busy");

	// The data pin is only driven while chip enable is high.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_drive |-> chip_enable)
		else $error("data pin driven with chip enable low");

	// A released data pin carries a low output level.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_drive |-> !data_pin_out)
		else $error("data level set while released");

	// The queue is never both full and empty, and intake stops only when it is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty) && (in_ready || q_full))
		else $error("queue status inconsistent");

endmodule
